[hdl/plslm_pkg.sv]
// ----------------------------------------------------------------------------
// plslm_pkg
// shared types and constants for the pinned lru slot list manager
// ----------------------------------------------------------------------------
`default_nettype none

package plslm_pkg;

    localparam int SLOT_COUNT = 128;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [7:0] CHAIN_END = 8'd255;

    typedef enum logic [2:0] {
        FUNC_INSERT = 3'd0,
        FUNC_TOUCH  = 3'd1,
        FUNC_DELETE = 3'd2,
        FUNC_ERASE  = 3'd3,
        FUNC_NEXT   = 3'd4,
        FUNC_READ   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ALL_PIN   = 3'd1,
        ST_NO_ROOT   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_PINNED    = 3'd4,
        ST_INVALID   = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] slot;
        logic       pin_entry;
        logic [7:0] user_flags;
        logic [6:0] issuer_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] result_slot;
        logic       evicted;
        logic [6:0] evicted_slot;
        logic       entry_used;
        logic       entry_pinned;
        logic [7:0] entry_flags;
        logic [6:0] entry_parent;
    } out_item_t;

    // per-slot record: link, used, pinned, flags, parent
    typedef struct packed {
        logic [7:0] link;
        logic       used;
        logic       pinned;
        logic [7:0] flags;
        logic [6:0] parent;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic slot_ok(input logic [7:0] s);
        return (s != 8'd0) && (32'(s) < SLOT_COUNT);
    endfunction

    function automatic entry_t reset_entry(input logic [SLOT_W-1:0] a);
        entry_t e;
        e = '0;
        if ((a == '0) || (32'(a) == SLOT_COUNT - 1))
            e.link = CHAIN_END;
        else
            e.link = 8'(a) + 8'd1;
        return e;
    endfunction

endpackage

`default_nettype wire

[hdl/plslm_if.sv]
// ----------------------------------------------------------------------------
// plslm_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
`default_nettype none

interface plslm_in_if;
    logic                valid;
    logic                ready;
    plslm_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface plslm_out_if;
    logic                 valid;
    logic                 ready;
    plslm_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/plslm_ram.sv]
// ----------------------------------------------------------------------------
// plslm_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module plslm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hdl/plslm_seq.sv]
// ----------------------------------------------------------------------------
// plslm_seq
// sequencer: walks the chains through the shared entry memory port
// ----------------------------------------------------------------------------
`default_nettype none

module plslm_seq (
    input  wire logic       clk,
    input  wire logic       rst_n,
    plslm_in_if.sink        in_ch,
    plslm_out_if.source     out_ch
);

    localparam int AW = plslm_pkg::SLOT_W;
    localparam logic [7:0] END = plslm_pkg::CHAIN_END;

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_DECODE  = 14'b00000000000100,
        S_TGT     = 14'b00000000001000,
        S_VWALK   = 14'b00000000010000,
        S_UWALK   = 14'b00000000100000,
        S_UFIX    = 14'b00000001000000,
        S_RELW    = 14'b00000010000000,
        S_PUSHW   = 14'b00000100000000,
        S_ALLOCR  = 14'b00001000000000,
        S_ALLOCW  = 14'b00010000000000,
        S_OUT     = 14'b00100000000000,
        S_RDWAIT  = 14'b01000000000000,
        S_WAIT    = 14'b10000000000000
    } state_t;

    // what to do after the used-chain unlink finishes
    typedef enum logic [1:0] {
        AFT_TOUCH = 2'd0,
        AFT_DEL   = 2'd1,
        AFT_EVICT = 2'd2
    } after_t;

    state_t state_reg, state_next;
    after_t after_reg, after_next;
    plslm_pkg::in_item_t  item_reg, item_next;
    plslm_pkg::out_item_t res_reg, res_next;
    logic [7:0] used_head_reg, used_head_next;
    logic [7:0] free_head_reg, free_head_next;
    logic [7:0] cur_reg, cur_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] victim_reg, victim_next;
    logic [7:0] tgt_reg, tgt_next;
    logic [7:0] steps_reg, steps_next;
    logic [AW:0] clr_reg, clr_next;
    logic        out_valid_reg, out_valid_next;

    logic                          we;
    logic [AW-1:0]                 addr;
    plslm_pkg::entry_t             wdata;
    plslm_pkg::entry_t             rdata;
    logic [plslm_pkg::ENTRY_W-1:0] rdata_raw;

    assign rdata = plslm_pkg::entry_t'(rdata_raw);

    plslm_ram #(
        .WIDTH (plslm_pkg::ENTRY_W),
        .DEPTH (plslm_pkg::SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata_raw)
    );

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            after_reg     <= AFT_TOUCH;
            used_head_reg <= END;
            free_head_reg <= 8'd1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            used_head_reg <= used_head_next;
            free_head_reg <= free_head_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        victim_reg <= victim_next;
        tgt_reg    <= tgt_next;
        steps_reg  <= steps_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        used_head_next = used_head_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        victim_next    = victim_reg;
        tgt_next       = tgt_reg;
        steps_next     = steps_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        we             = 1'b0;
        addr           = cur_reg[AW-1:0];
        wdata          = rdata;

        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                addr  = clr_reg[AW-1:0];
                wdata = plslm_pkg::reset_entry(clr_reg[AW-1:0]);
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == plslm_pkg::SLOT_COUNT - 1)
                begin
                    used_head_next = END;
                    free_head_next = 8'd1;
                    if (out_valid_reg && !out_ch.ready)
                        state_next = S_WAIT;
                    else
                        state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                addr = in_ch.payload.slot[AW-1:0];
                if (in_ch.valid)
                begin
                    item_next = in_ch.payload;
                    res_next  = '0;
                    res_next.result_slot = END;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // rdata holds the entry at item slot
                steps_next = '0;
                prev_next  = END;
                cur_next   = used_head_reg;
                tgt_next   = item_reg.slot;
                case (item_reg.func)
                    plslm_pkg::FUNC_INSERT:
                    begin
                        if (!plslm_pkg::slot_ok(used_head_reg) && !item_reg.pin_entry)
                        begin
                            res_next.status = plslm_pkg::ST_NO_ROOT;
                            state_next = S_OUT;
                        end
                        else if (!plslm_pkg::slot_ok(free_head_reg))
                        begin
                            victim_next = END;
                            state_next  = S_VWALK;
                        end
                        else
                        begin
                            cur_next   = free_head_reg;
                            state_next = S_ALLOCR;
                        end
                    end
                    plslm_pkg::FUNC_TOUCH, plslm_pkg::FUNC_DELETE:
                    begin
                        res_next.result_slot = item_reg.slot;
                        if (!plslm_pkg::slot_ok(item_reg.slot))
                        begin
                            res_next.status = plslm_pkg::ST_INVALID;
                            state_next = S_OUT;
                        end
                        else if (rdata.pinned)
                        begin
                            res_next.status = plslm_pkg::ST_PINNED;
                            state_next = S_OUT;
                        end
                        else if (!rdata.used)
                        begin
                            res_next.status = plslm_pkg::ST_NOT_FOUND;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            after_next = (item_reg.func == plslm_pkg::FUNC_TOUCH) ?
                                         AFT_TOUCH : AFT_DEL;
                            state_next = S_UWALK;
                        end
                    end
                    plslm_pkg::FUNC_ERASE:
                    begin
                        clr_next       = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    plslm_pkg::FUNC_NEXT:
                    begin
                        if (item_reg.slot == 8'd0)
                            res_next.result_slot = used_head_reg;
                        else if (plslm_pkg::slot_ok(item_reg.slot) && rdata.used)
                            res_next.result_slot = rdata.link;
                        state_next = S_OUT;
                    end
                    plslm_pkg::FUNC_READ:
                    begin
                        res_next.result_slot = item_reg.slot;
                        if (!plslm_pkg::slot_ok(item_reg.slot))
                            res_next.status = plslm_pkg::ST_INVALID;
                        else
                        begin
                            res_next.entry_used   = rdata.used;
                            res_next.entry_pinned = rdata.pinned;
                            res_next.entry_flags  = rdata.flags;
                            res_next.entry_parent = rdata.parent;
                        end
                        state_next = S_OUT;
                    end
                    default:
                        state_next = S_OUT;
                endcase
            end

            // victim search: even step issues the read of cur, odd step checks it
            S_VWALK:
            begin
                if (steps_reg[0] == 1'b0)
                begin
                    if (!plslm_pkg::slot_ok(cur_reg))
                    begin
                        if (!plslm_pkg::slot_ok(victim_reg))
                        begin
                            res_next.status = plslm_pkg::ST_ALL_PIN;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            tgt_next   = victim_reg;
                            after_next = AFT_EVICT;
                            cur_next   = used_head_reg;
                            prev_next  = END;
                            steps_next = '0;
                            state_next = S_UWALK;
                        end
                    end
                    else
                        steps_next = steps_reg + 8'd1;
                end
                else
                begin
                    if (!rdata.pinned)
                        victim_next = cur_reg;
                    cur_next   = rdata.link;
                    steps_next = steps_reg + 8'd1;
                end
            end

            S_TGT:
                state_next = S_UWALK;

            // unlink walk over the used chain; even step issues, odd step checks
            S_UWALK:
            begin
                if (steps_reg[0] == 1'b0)
                begin
                    if (!plslm_pkg::slot_ok(cur_reg))
                        state_next = S_RELW;
                    else
                        steps_next = steps_reg + 8'd1;
                end
                else if (cur_reg == tgt_reg)
                begin
                    if (prev_reg == END)
                    begin
                        used_head_next = rdata.link;
                        state_next     = S_RELW;
                    end
                    else
                    begin
                        victim_next = rdata.link;
                        cur_next    = prev_reg;
                        state_next  = S_UFIX;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rdata.link;
                    steps_next = steps_reg + 8'd1;
                end
            end

            // read prev, then link it past the target
            S_UFIX:
            begin
                if (steps_reg[0] == 1'b1)
                    steps_next = steps_reg + 8'd1;
                else
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    wdata.link = victim_reg;
                    state_next = S_RELW;
                end
            end

            // release or relink of the target
            S_RELW:
            begin
                addr = tgt_reg[AW-1:0];
                if (steps_reg[0] == 1'b1 || steps_reg == 8'hff)
                begin
                    steps_next = 8'd0;
                end
                else if (after_reg == AFT_TOUCH)
                    state_next = S_PUSHW;
                else
                begin
                    // read of tgt is registered; write next cycle
                    state_next = S_PUSHW;
                end
            end

            S_PUSHW:
            begin
                addr = tgt_reg[AW-1:0];
                we   = 1'b1;
                wdata = rdata;
                if (after_reg == AFT_TOUCH)
                begin
                    wdata.link     = used_head_reg;
                    used_head_next = tgt_reg;
                    state_next     = S_OUT;
                end
                else
                begin
                    wdata.used     = 1'b0;
                    wdata.pinned   = 1'b0;
                    wdata.link     = free_head_reg;
                    free_head_next = tgt_reg;
                    if (after_reg == AFT_EVICT)
                    begin
                        res_next.evicted      = 1'b1;
                        res_next.evicted_slot = tgt_reg[6:0];
                        cur_next              = tgt_reg;
                        state_next            = S_ALLOCR;
                    end
                    else
                        state_next = S_OUT;
                end
            end

            S_ALLOCR:
                state_next = S_ALLOCW;

            S_ALLOCW:
            begin
                we             = 1'b1;
                wdata.link     = used_head_reg;
                wdata.used     = 1'b1;
                wdata.pinned   = item_reg.pin_entry;
                wdata.flags    = item_reg.user_flags;
                wdata.parent   = item_reg.pin_entry ? cur_reg[6:0] : item_reg.issuer_slot;
                free_head_next = rdata.link;
                used_head_next = cur_reg;
                res_next.result_slot = cur_reg;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
            end

            S_RDWAIT:
                state_next = S_IDLE;

            S_WAIT:
            begin
                if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        if (out_valid_reg && out_ch.ready && state_reg != S_WAIT)
            out_valid_next = 1'b0;
    end

endmodule

`default_nettype wire

[hdl/pinned_lru_slot_list_manager_core.sv]
// ----------------------------------------------------------------------------
// pinned_lru_slot_list_manager_core
// lru slot list manager with pinned entries over one entry memory
// ----------------------------------------------------------------------------
// flow: read, next, erase and rejected items give their result straight after
// decode, a plain insert after reading and writing the free head; touch, delete
// and evicting insert walk the used chain with a read and a check per visited
// entry, an evicting insert walking it for the victim and again to unlink it
// throughput: one item at a time, the next item is taken after the result is taken
// reset: a clearing pass over all SLOT_COUNT entries runs before the first item;
// erase all runs the same pass
`default_nettype none

module pinned_lru_slot_list_manager_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    plslm_in_if.sink    in_ch,
    plslm_out_if.source out_ch
);

    plslm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    a_no_ready_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while a result waits");

    a_out_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready |=> !out_ch.valid)
        else $error("result repeated");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.payload.status <= 3'd5)
        else $error("bad status");

endmodule

`default_nettype wire
